// ----- rtl/i2c_ram_pkg.sv -----
`default_nettype none
package i2c_ram_pkg;

   localparam logic       KIND_TICK    = 1'b0;
   localparam logic       KIND_REQUEST = 1'b1;

   localparam logic [1:0] OP_WRITE_BYTE = 2'd0;
   localparam logic [1:0] OP_WRITE_WORD = 2'd1;
   localparam logic [1:0] OP_READ_BYTE  = 2'd2;
   localparam logic [1:0] OP_READ_WORD  = 2'd3;

   localparam logic       RW_WRITE = 1'b0;
   localparam logic       RW_READ  = 1'b1;

   localparam logic [6:0]  ADDRESS_RESET = 7'd41;
   localparam logic [15:0] COUNT_FULL    = 16'hFFFF;
   localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

   localparam logic [1:0] PHASE_LOW_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_HIGH_FIRST = 2'd1;
   localparam logic [1:0] PHASE_SAMPLE     = 2'd2;
   localparam logic [1:0] PHASE_LAST       = 2'd3;

   localparam logic [2:0] STEP_INDEX  = 3'd1;
   localparam logic [2:0] STEP_SECOND = 3'd2;
   localparam logic [2:0] STEP_THIRD  = 3'd3;

   typedef enum logic [3:0] {
      SEQ_IDLE     = 4'd0,
      SEQ_START    = 4'd1,
      SEQ_TX       = 4'd2,
      SEQ_TXACK    = 4'd3,
      SEQ_RSTART   = 4'd4,
      SEQ_RX       = 4'd5,
      SEQ_RXACK    = 4'd6,
      SEQ_STOP_OK  = 4'd7,
      SEQ_STOP_ERR = 4'd8
   } seq_state_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  op;
      logic [7:0]  reg_index;
      logic [15:0] write_data;
      logic        sda_in;
   } req_type;

   typedef struct packed {
      logic        scl_out;
      logic        sda_out;
      logic        busy_res;
      logic        done_res;
      logic        nack_error;
      logic [15:0] read_data;
      logic [15:0] error_count;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  reg_index;
      logic [15:0] write_data;
   } latch_type;

endpackage
`default_nettype wire

// ----- rtl/i2c_ram_sequencer.sv -----
`default_nettype none
module i2c_ram_sequencer (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  step_en,
   input  i2c_ram_pkg::req_type item,
   input  wire                  csr_write_enable,
   input  wire  [6:0]           csr_write_data,
   output i2c_ram_pkg::rsp_type result
);
   import i2c_ram_pkg::*;

   seq_state_type state_ff, state_in;
   logic [1:0]    phase_count_ff, phase_count_in;
   logic [3:0]    bit_count_ff, bit_count_in;
   logic [2:0]    byte_step_ff, byte_step_in;
   logic [7:0]    shift_byte_ff, shift_byte_in;
   latch_type     latch_ff, latch_in;
   logic [15:0]   read_accum_ff, read_accum_in;
   logic [15:0]   nack_total_ff, nack_total_in;
   logic          scl_hold_ff, scl_hold_in;
   logic          sda_hold_ff, sda_hold_in;
   logic [6:0]    slave_address_ff;

   logic          drive_scl, drive_sda;
   logic          last_phase, clk_high, more_bytes;
   logic [3:0]    bit_next;
   logic [2:0]    step_next;

   assign last_phase = (phase_count_ff == PHASE_LAST);
   assign clk_high   = (phase_count_ff == PHASE_HIGH_FIRST) || (phase_count_ff == PHASE_SAMPLE);
   assign more_bytes = (latch_ff.op == OP_READ_WORD) && (byte_step_ff == STEP_THIRD);
   assign bit_next   = bit_count_ff + 4'd1;
   assign step_next  = byte_step_ff + 3'd1;

   always_comb begin : drive_logic
      drive_scl = clk_high;
      drive_sda = 1'b1;
      case (state_ff)
         SEQ_START: begin
            drive_scl = (phase_count_ff < PHASE_SAMPLE);
            drive_sda = (phase_count_ff == PHASE_LOW_FIRST);
         end
         SEQ_RSTART: begin
            drive_sda = (phase_count_ff < PHASE_SAMPLE);
         end
         SEQ_TX: begin
            drive_sda = shift_byte_ff[7];
         end
         SEQ_TXACK, SEQ_RX: begin
            drive_sda = 1'b1;
         end
         SEQ_RXACK: begin
            drive_sda = !more_bytes;
         end
         SEQ_STOP_OK, SEQ_STOP_ERR: begin
            drive_scl = (phase_count_ff != PHASE_LOW_FIRST);
            drive_sda = (phase_count_ff >= PHASE_SAMPLE);
         end
         default: begin
            drive_scl = 1'b1;
            drive_sda = 1'b1;
         end
      endcase
   end

   always_comb begin : next_logic
      state_in       = state_ff;
      phase_count_in = phase_count_ff;
      bit_count_in   = bit_count_ff;
      byte_step_in   = byte_step_ff;
      shift_byte_in  = shift_byte_ff;
      latch_in       = latch_ff;
      read_accum_in  = read_accum_ff;
      nack_total_in  = nack_total_ff;
      scl_hold_in    = scl_hold_ff;
      sda_hold_in    = sda_hold_ff;
      if (item.kind == KIND_REQUEST) begin
         if (state_ff == SEQ_IDLE) begin
            latch_in.op         = item.op;
            latch_in.reg_index  = item.reg_index;
            latch_in.write_data = item.write_data;
            state_in            = SEQ_START;
            phase_count_in      = '0;
            bit_count_in        = '0;
            byte_step_in        = '0;
            shift_byte_in       = '0;
            read_accum_in       = '0;
         end
      end else begin
         case (state_ff)
            SEQ_START: begin
               if (last_phase) begin
                  shift_byte_in = {slave_address_ff, RW_WRITE};
                  bit_count_in  = '0;
                  state_in      = SEQ_TX;
               end
            end
            SEQ_RSTART: begin
               if (last_phase) begin
                  shift_byte_in = {slave_address_ff, RW_READ};
                  bit_count_in  = '0;
                  state_in      = SEQ_TX;
               end
            end
            SEQ_TX: begin
               if (last_phase) begin
                  shift_byte_in = {shift_byte_ff[6:0], 1'b0};
                  if (bit_next >= BITS_PER_BYTE) begin
                     bit_count_in = '0;
                     state_in     = SEQ_TXACK;
                  end else begin
                     bit_count_in = bit_next;
                  end
               end
            end
            SEQ_TXACK: begin
               if (phase_count_ff == PHASE_SAMPLE) begin
                  bit_count_in = {3'b000, item.sda_in};
               end
               if (last_phase) begin
                  bit_count_in = '0;
                  if (bit_count_ff[0]) begin
                     if (nack_total_ff != COUNT_FULL) begin
                        nack_total_in = nack_total_ff + 16'd1;
                     end
                     state_in = SEQ_STOP_ERR;
                  end else begin
                     byte_step_in = step_next;
                     if (step_next == STEP_INDEX) begin
                        shift_byte_in = latch_ff.reg_index;
                        state_in      = SEQ_TX;
                     end else if (latch_ff.op == OP_WRITE_BYTE) begin
                        if (step_next == STEP_SECOND) begin
                           shift_byte_in = latch_ff.write_data[7:0];
                           state_in      = SEQ_TX;
                        end else begin
                           state_in = SEQ_STOP_OK;
                        end
                     end else if (latch_ff.op == OP_WRITE_WORD) begin
                        if (step_next == STEP_SECOND) begin
                           shift_byte_in = latch_ff.write_data[15:8];
                           state_in      = SEQ_TX;
                        end else if (step_next == STEP_THIRD) begin
                           shift_byte_in = latch_ff.write_data[7:0];
                           state_in      = SEQ_TX;
                        end else begin
                           state_in = SEQ_STOP_OK;
                        end
                     end else if (step_next == STEP_SECOND) begin
                        state_in = SEQ_RSTART;
                     end else begin
                        shift_byte_in = '0;
                        state_in      = SEQ_RX;
                     end
                  end
               end
            end
            SEQ_RX: begin
               if (phase_count_ff == PHASE_SAMPLE) begin
                  shift_byte_in = {shift_byte_ff[6:0], item.sda_in};
               end
               if (last_phase) begin
                  if (bit_next >= BITS_PER_BYTE) begin
                     bit_count_in = '0;
                     state_in     = SEQ_RXACK;
                  end else begin
                     bit_count_in = bit_next;
                  end
               end
            end
            SEQ_RXACK: begin
               if (last_phase) begin
                  read_accum_in = {read_accum_ff[7:0], shift_byte_ff};
                  byte_step_in  = step_next;
                  if (more_bytes) begin
                     shift_byte_in = '0;
                     bit_count_in  = '0;
                     state_in      = SEQ_RX;
                  end else begin
                     state_in = SEQ_STOP_OK;
                  end
               end
            end
            SEQ_STOP_OK, SEQ_STOP_ERR: begin
               if (last_phase) begin
                  state_in = SEQ_IDLE;
               end
            end
            default: begin
               state_in = SEQ_IDLE;
            end
         endcase
         phase_count_in = (state_in == SEQ_IDLE) ? 2'd0 : phase_count_ff + 2'd1;
         scl_hold_in    = drive_scl;
         sda_hold_in    = drive_sda;
      end
   end

   always_comb begin : output_logic
      logic stopping;
      stopping = (state_ff == SEQ_STOP_OK) || (state_ff == SEQ_STOP_ERR);
      result.busy_res    = (state_in != SEQ_IDLE);
      result.error_count = nack_total_in;
      result.done_res    = 1'b0;
      result.nack_error  = 1'b0;
      result.read_data   = '0;
      if (item.kind == KIND_REQUEST) begin
         result.scl_out = scl_hold_ff;
         result.sda_out = sda_hold_ff;
      end else begin
         result.scl_out = drive_scl;
         result.sda_out = drive_sda;
         if (stopping && last_phase) begin
            result.done_res   = 1'b1;
            result.nack_error = (state_ff == SEQ_STOP_ERR);
            if ((state_ff == SEQ_STOP_OK) && latch_ff.op[1]) begin
               result.read_data = read_accum_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= ADDRESS_RESET;
      end else if (csr_write_enable) begin
         slave_address_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= SEQ_IDLE;
         phase_count_ff <= '0;
         bit_count_ff   <= '0;
         byte_step_ff   <= '0;
         shift_byte_ff  <= '0;
         latch_ff       <= '0;
         read_accum_ff  <= '0;
         nack_total_ff  <= '0;
         scl_hold_ff    <= 1'b1;
         sda_hold_ff    <= 1'b1;
      end else if (step_en) begin
         state_ff       <= state_in;
         phase_count_ff <= phase_count_in;
         bit_count_ff   <= bit_count_in;
         byte_step_ff   <= byte_step_in;
         shift_byte_ff  <= shift_byte_in;
         latch_ff       <= latch_in;
         read_accum_ff  <= read_accum_in;
         nack_total_ff  <= nack_total_in;
         scl_hold_ff    <= scl_hold_in;
         sda_hold_ff    <= sda_hold_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      step_en && (state_ff == SEQ_IDLE) && (item.kind == KIND_TICK)
      |-> result.scl_out && result.sda_out && !result.done_res)
      else $error("idle tick did not release the bus");

   assert property (@(posedge clock) disable iff (reset)
      step_en && result.nack_error |-> result.done_res && !result.busy_res)
      else $error("error flag without completion");

   assert property (@(posedge clock) disable iff (reset)
      (!reset && !$past(reset)) |-> (nack_total_ff >= $past(nack_total_ff)))
      else $error("error count decreased");

   assert property (@(posedge clock) disable iff (reset)
      step_en && (item.kind == KIND_TICK) && (state_ff != SEQ_IDLE) && (state_in != SEQ_IDLE)
      |=> phase_count_ff == $past(phase_count_ff) + 2'd1)
      else $error("timing phase did not advance");

endmodule
`default_nettype wire

// ----- rtl/i2c_register_access_master.sv -----
`default_nettype none
// I2C master for single-register transactions with an 8-bit register index. Each request
// word with kind set to request starts a transaction when the sequencer is idle; each tick
// word steps one quarter-bit phase and every word returns one response word with the SCL and
// SDA drive levels, busy, done, error flag, read data and the saturating NACK count. A word
// passes through an input register and the sequencer into the response register, so a new
// word is accepted every clock when the response side is not stalled, and its response is
// held in the response register until it is taken. The slave
// address register may be written only while no word is in flight.
module i2c_register_access_master (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  i2c_ram_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output i2c_ram_pkg::rsp_type rsp_data,
   input  wire                  csr_write_enable,
   input  wire  [6:0]           csr_write_data
);
   import i2c_ram_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type step_result;
   logic    out_free, step_en;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_en   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (step_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (step_en) begin
         rsp_data_ff <= step_result;
      end
   end

   i2c_ram_sequencer u_sequencer (
      .clock            (clock),
      .reset            (reset),
      .step_en          (step_en),
      .item             (in_data_ff),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .result           (step_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ----- test/i2c_register_access_master_tb.sv -----
`default_nettype none
module i2c_register_access_master_tb;
   import i2c_ram_pkg::*;

   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 200;
   localparam int STALL_LIMIT     = 2000;
   localparam int LONG_HOLD       = 60;
   localparam int DIRECTED_ROWS   = 17;

   typedef struct packed {
      req_type word;
      logic    checked;
      rsp_type want;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_ready;
   rsp_type       rsp_data;
   logic          csr_write_enable;
   logic [6:0]    csr_write_data;

   seq_state_type bus_state;
   logic [1:0]    bus_phase;
   logic [3:0]    bit_cnt;
   logic [2:0]    byte_step;
   logic [7:0]    shift_reg;
   latch_type     held_req;
   logic [15:0]   read_acc;
   logic [15:0]   nack_cnt;
   logic          scl_level;
   logic          sda_level;
   logic [6:0]    target_addr;

   rsp_type       bus_expect_q[$];
   logic          row_checked;
   rsp_type       row_want;
   int            sender_gap_max;
   int            receiver_gap_max;
   bit            hold_rsp_req;
   int            mismatches;
   int            quiet_cycles;

   i2c_register_access_master u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   task automatic load_byte(input logic [7:0] b);
      shift_reg = b;
      bit_cnt = '0;
      bus_state = SEQ_TX;
   endtask

   // Chooses the next byte or sequence once the slave has acknowledged a byte.
   task automatic ack_advance();
      byte_step = byte_step + 3'd1;
      if (byte_step == STEP_INDEX) begin
         load_byte(held_req.reg_index);
      end else begin
         case (held_req.op)
            OP_WRITE_BYTE: begin
               if (byte_step == STEP_SECOND) load_byte(held_req.write_data[7:0]);
               else bus_state = SEQ_STOP_OK;
            end
            OP_WRITE_WORD: begin
               if (byte_step == STEP_SECOND) load_byte(held_req.write_data[15:8]);
               else if (byte_step == STEP_THIRD) load_byte(held_req.write_data[7:0]);
               else bus_state = SEQ_STOP_OK;
            end
            default: begin
               if (byte_step == STEP_SECOND) begin
                  bus_state = SEQ_RSTART;
               end else begin
                  shift_reg = '0;
                  bit_cnt = '0;
                  bus_state = SEQ_RX;
               end
            end
         endcase
      end
   endtask

   task automatic predict_bus_word(input req_type w, output rsp_type r);
      logic        scl;
      logic        sda;
      logic        done;
      logic        err;
      logic [15:0] rdata;
      logic [1:0]  ph;
      logic        last;
      logic        clk_high;
      logic        more;
      scl = scl_level;
      sda = sda_level;
      done = 1'b0;
      err = 1'b0;
      rdata = '0;
      ph = bus_phase;
      last = (ph == PHASE_LAST);
      clk_high = (ph == PHASE_HIGH_FIRST) || (ph == PHASE_SAMPLE);
      if (w.kind == KIND_REQUEST) begin
         if (bus_state == SEQ_IDLE) begin
            held_req = '{op: w.op, reg_index: w.reg_index, write_data: w.write_data};
            bus_state = SEQ_START;
            bus_phase = '0;
            bit_cnt = '0;
            byte_step = '0;
            shift_reg = '0;
            read_acc = '0;
         end
      end else begin
         case (bus_state)
            SEQ_START: begin
               scl = (ph < PHASE_SAMPLE);
               sda = (ph == PHASE_LOW_FIRST);
               if (last) load_byte({target_addr, RW_WRITE});
            end
            SEQ_RSTART: begin
               scl = clk_high;
               sda = (ph < PHASE_SAMPLE);
               if (last) load_byte({target_addr, RW_READ});
            end
            SEQ_TX: begin
               scl = clk_high;
               sda = shift_reg[7];
               if (last) begin
                  shift_reg = {shift_reg[6:0], 1'b0};
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt >= BITS_PER_BYTE) begin
                     bit_cnt = '0;
                     bus_state = SEQ_TXACK;
                  end
               end
            end
            SEQ_TXACK: begin
               scl = clk_high;
               sda = 1'b1;
               if (ph == PHASE_SAMPLE) bit_cnt = {3'b000, w.sda_in};
               if (last) begin
                  if (bit_cnt[0]) begin
                     if (nack_cnt != COUNT_FULL) nack_cnt = nack_cnt + 16'd1;
                     bus_state = SEQ_STOP_ERR;
                  end else begin
                     ack_advance();
                  end
                  if (bus_state != SEQ_TX && bus_state != SEQ_RX) bit_cnt = '0;
               end
            end
            SEQ_RX: begin
               scl = clk_high;
               sda = 1'b1;
               if (ph == PHASE_SAMPLE) shift_reg = {shift_reg[6:0], w.sda_in};
               if (last) begin
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt >= BITS_PER_BYTE) begin
                     bit_cnt = '0;
                     bus_state = SEQ_RXACK;
                  end
               end
            end
            SEQ_RXACK: begin
               more = (held_req.op == OP_READ_WORD) && (byte_step == STEP_THIRD);
               scl = clk_high;
               sda = !more;
               if (last) begin
                  read_acc = {read_acc[7:0], shift_reg};
                  byte_step = byte_step + 3'd1;
                  if (more) begin
                     shift_reg = '0;
                     bit_cnt = '0;
                     bus_state = SEQ_RX;
                  end else begin
                     bus_state = SEQ_STOP_OK;
                  end
               end
            end
            SEQ_STOP_OK, SEQ_STOP_ERR: begin
               scl = (ph != PHASE_LOW_FIRST);
               sda = (ph >= PHASE_SAMPLE);
               if (last) begin
                  done = 1'b1;
                  err = (bus_state == SEQ_STOP_ERR);
                  if (!err && held_req.op[1]) rdata = read_acc;
                  bus_state = SEQ_IDLE;
               end
            end
            default: begin
               bus_state = SEQ_IDLE;
               scl = 1'b1;
               sda = 1'b1;
            end
         endcase
         if (bus_state == SEQ_IDLE) begin
            if (!done) begin
               scl = 1'b1;
               sda = 1'b1;
            end
            bus_phase = '0;
         end else begin
            bus_phase = ph + 2'd1;
         end
         scl_level = scl;
         sda_level = sda;
      end
      r.scl_out = scl;
      r.sda_out = sda;
      r.busy_res = (bus_state != SEQ_IDLE);
      r.done_res = done;
      r.nack_error = err;
      r.read_data = rdata;
      r.error_count = nack_cnt;
   endtask

   function automatic req_type tick_word(input logic sda);
      req_type w;
      w = '0;
      w.kind = KIND_TICK;
      w.sda_in = sda;
      return w;
   endfunction

   function automatic req_type request_word(input logic [1:0] op, input logic [7:0] idx,
                                            input logic [15:0] data);
      req_type w;
      w = '0;
      w.kind = KIND_REQUEST;
      w.op = op;
      w.reg_index = idx;
      w.write_data = data;
      return w;
   endfunction

   function automatic rsp_type bus_levels(input logic scl, input logic sda, input logic busy);
      rsp_type r;
      r = '0;
      r.scl_out = scl;
      r.sda_out = sda;
      r.busy_res = busy;
      return r;
   endfunction

   // Plays a slave that mostly acknowledges, looking at where the bus sequencer stands now.
   function automatic req_type next_bus_word();
      req_type w;
      w.kind = KIND_TICK;
      w.op = 2'($urandom);
      w.reg_index = ($urandom_range(0, 3) == 0) ?
                    (($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00) : 8'($urandom);
      w.write_data = ($urandom_range(0, 3) == 0) ?
                     (($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000) : 16'($urandom);
      w.sda_in = 1'($urandom);
      if (bus_state == SEQ_IDLE) begin
         if ($urandom_range(0, 9) < 8) w.kind = KIND_REQUEST;
      end else if ($urandom_range(0, 39) == 0) begin
         w.kind = KIND_REQUEST;
      end
      if (bus_state == SEQ_TXACK && bus_phase == PHASE_SAMPLE) begin
         w.sda_in = ($urandom_range(0, 14) == 0);
      end
      return w;
   endfunction

   task automatic send_word(input req_type w, input logic checked, input rsp_type want);
      int gap;
      gap = $urandom_range(0, sender_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      row_checked = checked;
      row_want = want;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_bus_word(req_data, predicted);
            bus_expect_q.push_back(row_checked ? row_want : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (bus_expect_q.size() == 0) begin
               report_mismatch("response word with nothing expected");
            end else begin
               want = bus_expect_q.pop_front();
               check_field("scl_out", rsp_data.scl_out, want.scl_out);
               check_field("sda_out", rsp_data.sda_out, want.sda_out);
               check_field("busy_res", rsp_data.busy_res, want.busy_res);
               check_field("done_res", rsp_data.done_res, want.done_res);
               check_field("nack_error", rsp_data.nack_error, want.nack_error);
               check_field("read_data", rsp_data.read_data, want.read_data);
               check_field("error_count", rsp_data.error_count, want.error_count);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   initial begin
      int stall;
      forever begin
         @(negedge clock);
         stall = $urandom_range(0, receiver_gap_max);
         if (hold_rsp_req) begin
            stall = LONG_HOLD;
            hold_rsp_req = 1'b0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      stim_row_type rows [DIRECTED_ROWS];
      req_type      w;
      int           counted;
      logic [6:0]   addr;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      sender_gap_max = 4;
      receiver_gap_max = 4;
      hold_rsp_req = 1'b0;
      mismatches = 0;
      quiet_cycles = 0;
      row_checked = 1'b0;
      row_want = '0;
      target_addr = ADDRESS_RESET;
      bus_state = SEQ_IDLE;
      bus_phase = '0;
      bit_cnt = '0;
      byte_step = '0;
      shift_reg = '0;
      held_req = '0;
      read_acc = '0;
      nack_cnt = '0;
      scl_level = 1'b1;
      sda_level = 1'b1;

      // The start condition and the first two bits of the reset address byte.
      rows[0]  = '{tick_word(1'b1), 1'b1, bus_levels(1'b1, 1'b1, 1'b0)};
      rows[1]  = '{tick_word(1'b0), 1'b1, bus_levels(1'b1, 1'b1, 1'b0)};
      rows[2]  = '{request_word(OP_READ_WORD, 8'hFF, 16'hFFFF), 1'b1,
                   bus_levels(1'b1, 1'b1, 1'b1)};
      rows[3]  = '{request_word(OP_WRITE_BYTE, 8'h00, 16'h0000), 1'b1,
                   bus_levels(1'b1, 1'b1, 1'b1)};
      rows[4]  = '{tick_word(1'b1), 1'b1, bus_levels(1'b1, 1'b1, 1'b1)};
      rows[5]  = '{tick_word(1'b0), 1'b1, bus_levels(1'b1, 1'b0, 1'b1)};
      rows[6]  = '{tick_word(1'b1), 1'b1, bus_levels(1'b0, 1'b0, 1'b1)};
      rows[7]  = '{tick_word(1'b0), 1'b1, bus_levels(1'b0, 1'b0, 1'b1)};
      rows[8]  = '{request_word(OP_WRITE_WORD, 8'h5A, 16'hA5A5), 1'b1,
                   bus_levels(1'b0, 1'b0, 1'b1)};
      rows[9]  = '{tick_word(1'b1), 1'b1, bus_levels(1'b0, 1'b0, 1'b1)};
      rows[10] = '{tick_word(1'b0), 1'b1, bus_levels(1'b1, 1'b0, 1'b1)};
      rows[11] = '{tick_word(1'b1), 1'b1, bus_levels(1'b1, 1'b0, 1'b1)};
      rows[12] = '{tick_word(1'b0), 1'b1, bus_levels(1'b0, 1'b0, 1'b1)};
      rows[13] = '{tick_word(1'b0), 1'b1, bus_levels(1'b0, 1'b1, 1'b1)};
      rows[14] = '{tick_word(1'b1), 1'b1, bus_levels(1'b1, 1'b1, 1'b1)};
      rows[15] = '{tick_word(1'b0), 1'b1, bus_levels(1'b1, 1'b1, 1'b1)};
      rows[16] = '{tick_word(1'b1), 1'b1, bus_levels(1'b0, 1'b1, 1'b1)};

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      foreach (rows[i]) send_word(rows[i].word, rows[i].checked, rows[i].want);

      for (int p = 0; p < PHASES; p++) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while (bus_expect_q.size() != 0) @(negedge clock);
         case (p)
            0, 5: addr = 7'h00;
            1, 4: addr = 7'h7F;
            2: addr = ADDRESS_RESET;
            default: addr = 7'($urandom);
         endcase
         csr_write_enable <= 1'b1;
         csr_write_data <= addr;
         @(negedge clock);
         csr_write_enable <= 1'b0;
         target_addr = addr;
         sender_gap_max = (p % 3 == 1) ? 0 : 4;
         receiver_gap_max = (p % 4 == 2) ? 0 : 4;
         if (p == 3) hold_rsp_req = 1'b1;
         counted = 0;
         while (counted < WORDS_PER_PHASE) begin
            w = next_bus_word();
            if ((w.kind == KIND_REQUEST) == (bus_state == SEQ_IDLE)) counted++;
            send_word(w, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (bus_expect_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire
